// ===== rtl/nsr_pkg.sv =====
package nsr_pkg;

   localparam int RAD_W = 32;
   localparam int ITER_W = 6;
   localparam int ROOT_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;
   localparam int PC_W = 3;

   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_IDLE = 3'd0;
   localparam pc_type PC_CHECK = 3'd1;
   localparam pc_type PC_DIV_INIT = 3'd2;
   localparam pc_type PC_DIV_STEP = 3'd3;
   localparam pc_type PC_UPDATE = 3'd4;
   localparam pc_type PC_DONE = 3'd5;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_UPDATE,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_SKIP,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type op;
      cond_type cond;
      pc_type jmp;
      pc_type nxt;
   } ucode_type;

   typedef struct packed {
      logic init;
      logic step;
   } div_ctrl_type;

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type word;
      unique case (pc)
         PC_IDLE: word = '{OP_LOAD, COND_NO_REQ, PC_IDLE, PC_CHECK};
         PC_CHECK: word = '{OP_NONE, COND_SKIP, PC_DONE, PC_DIV_INIT};
         PC_DIV_INIT: word = '{OP_DIV_INIT, COND_NEVER, PC_IDLE, PC_DIV_STEP};
         PC_DIV_STEP: word = '{OP_DIV_STEP, COND_DIV_MORE, PC_DIV_STEP, PC_UPDATE};
         PC_UPDATE: word = '{OP_UPDATE, COND_NEVER, PC_IDLE, PC_CHECK};
         PC_DONE: word = '{OP_EMIT, COND_OUT_BUSY, PC_DONE, PC_IDLE};
         default: word = '{OP_NONE, COND_NEVER, PC_IDLE, PC_IDLE};
      endcase
      return word;
   endfunction

endpackage

// ===== rtl/newton_square_root.sv =====
// Channel   Ports                     Contents
// request   req_tvalid/tready/tdata   radicand, iterations
// response  rsp_tvalid/tready/tdata   root
//
// Each Newton step runs the restoring divider, one quotient bit per cycle.
// Reset clears the microcode step counter and the response valid flag.
// A new request is taken only in the idle step; a held response does not block it.
// A stalled response holds its data until taken.
module newton_square_root #(
   parameter int WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [nsr_pkg::REQ_DATA_W-1:0]  req_tdata,  // radicand[31:0], iterations[37:32]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [nsr_pkg::RSP_DATA_W-1:0]  rsp_tdata   // root[31:0]
);
   import nsr_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + FRAC_BITS + 1);
   localparam int DIV_STEPS = WIDTH + FRAC_BITS;

   pc_type            pc_ff, pc_in;
   ucode_type         uword;
   logic              cond_true;
   logic              accept;
   logic              out_busy;
   logic [WIDTH-1:0]  rad_ff, rad_in;
   logic [WIDTH-1:0]  guess_ff, guess_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [WIDTH-1:0]  quo;
   logic [WIDTH:0]    sum;
   div_ctrl_type      div_ctrl;

   assign uword = ucode_rom(pc_ff);
   assign accept = req_tvalid && req_tready;
   assign out_busy = rsp_valid_ff && !rsp_tready;

   always_comb begin
      unique case (uword.cond)
         COND_NEVER: cond_true = 1'b0;
         COND_NO_REQ: cond_true = !req_tvalid;
         COND_SKIP: cond_true = (rad_ff == '0) || (iter_ff == '0) || (guess_ff == '0);
         COND_DIV_MORE: cond_true = (cnt_ff != CNT_W'(1));
         COND_OUT_BUSY: cond_true = out_busy;
         default: cond_true = 1'b0;
      endcase
      pc_in = cond_true ? uword.jmp : uword.nxt;
   end

   always_comb begin
      req_tready = (uword.op == OP_LOAD);
      div_ctrl.init = (uword.op == OP_DIV_INIT);
      div_ctrl.step = (uword.op == OP_DIV_STEP);
      sum = {1'b0, guess_ff} + {1'b0, quo};
      rad_in = rad_ff;
      guess_in = guess_ff;
      iter_in = iter_ff;
      cnt_in = cnt_ff;
      root_in = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (uword.op)
         OP_LOAD: begin
            if (accept) begin
               rad_in = WIDTH'(req_tdata[RAD_W-1:0]);
               guess_in = WIDTH'(req_tdata[RAD_W-1:0]);
               iter_in = req_tdata[RAD_W +: ITER_W];
            end
         end
         OP_DIV_INIT: cnt_in = CNT_W'(DIV_STEPS);
         OP_DIV_STEP: cnt_in = cnt_ff - CNT_W'(1);
         OP_UPDATE: begin
            guess_in = sum[WIDTH:1];
            iter_in = iter_ff - ITER_W'(1);
         end
         OP_EMIT: begin
            if (!out_busy) begin
               root_in = ROOT_W'(guess_ff);
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      guess_ff <= guess_in;
      iter_ff <= iter_in;
      cnt_ff <= cnt_in;
      root_ff <= root_in;
   end

   nsr_divider #(
      .WIDTH(WIDTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_divider (
      .clock(clock),
      .ctrl(div_ctrl),
      .num(rad_ff),
      .den(guess_ff),
      .quo(quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DATA_W'(root_ff);

endmodule

// ===== rtl/nsr_divider.sv =====
module nsr_divider #(
   parameter int WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  nsr_pkg::div_ctrl_type ctrl,
   input  logic [WIDTH-1:0]     num,
   input  logic [WIDTH-1:0]     den,
   output logic [WIDTH-1:0]     quo
);
   import nsr_pkg::*;

   localparam int NUM_W = WIDTH + FRAC_BITS;

   logic [NUM_W-1:0] num_ff, num_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic             over_ff, over_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      diff = shifted - {1'b0, den};
      ge = (shifted >= {1'b0, den});
      num_in = num_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      over_in = over_ff;
      if (ctrl.init) begin
         num_in = NUM_W'(num) << FRAC_BITS;
         rem_in = '0;
         quo_in = '0;
         over_in = 1'b0;
      end else if (ctrl.step) begin
         num_in = num_ff << 1;
         rem_in = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], ge};
         over_in = over_ff | quo_ff[WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      over_ff <= over_in;
   end

   assign quo = over_ff ? '1 : quo_ff;

endmodule

// ===== rtl/nsr_checker.sv =====
module nsr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [nsr_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import nsr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a request is in progress");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response appeared without a request in progress");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
